// File: design/bfs_pkg.sv
package bfs_pkg;

   // modular hash constants
   localparam logic [29:0] HASH_MOD   = 30'd1000000007;
   localparam logic [29:0] BASE_DEPTH = 30'd13331;
   localparam logic [29:0] BASE_CHILD = 30'd10007;

   // configuration register indexes
   localparam logic [0:0] REG_ROOT  = 1'b0;
   localparam logic [0:0] REG_COUNT = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_LOAD_WR,
      ST_START,
      ST_POP,
      ST_POP_WAIT,
      ST_POP_CHK,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_CHK,
      ST_PW_INIT,
      ST_PW_MUL,
      ST_PW_RED,
      ST_ACC,
      ST_DONE,
      ST_CLEAR
   } state_type;

   // power unit selector
   typedef enum logic [1:0] {
      PW_DEPTH,
      PW_CHILD,
      PW_COMBINE
   } pw_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load_write;
      logic       start_walk;
      logic       pop;
      logic       head_check;
      logic       mark_visit;
      logic       adj_read;
      logic       scan_check;
      logic       pw_init;
      pw_sel_type pw_sel;
      logic       pw_mul;
      logic       pw_red;
      logic       acc_add;
      logic       result_load;
      logic       clear_step;
      logic       clear_start;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic root_ok;
      logic queue_empty;
      logic head_visited;
      logic scan_more;
      logic pw_more;
      logic red_done;
      logic clear_done;
   } status_type;

endpackage

// File: design/bfs_ctrl.sv
module bfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                req_last,
   input  logic                rsp_free,
   input  bfs_pkg::status_type sts,
   output bfs_pkg::cmd_type    cmd,
   output logic                req_tready
);

   bfs_pkg::state_type state_ff, state_in;
   logic [1:0] pw_phase_ff, pw_phase_in;
   logic       last_ff, last_in;

   // state register, clearing pass runs first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bfs_pkg::ST_CLEAR;
         pw_phase_ff <= 2'd0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pw_phase_ff <= pw_phase_in;
         last_ff     <= last_in;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      pw_phase_in = pw_phase_ff;
      last_in     = last_ff;
      case (state_ff)
         bfs_pkg::ST_LOAD: begin
            if (req_fire) begin
               state_in = bfs_pkg::ST_LOAD_WR;
               last_in  = req_last;
            end
         end
         bfs_pkg::ST_LOAD_WR: begin
            state_in = last_ff ? bfs_pkg::ST_START : bfs_pkg::ST_LOAD;
         end
         bfs_pkg::ST_START: begin
            state_in = sts.root_ok ? bfs_pkg::ST_POP : bfs_pkg::ST_DONE;
         end
         bfs_pkg::ST_POP: begin
            state_in = sts.queue_empty ? bfs_pkg::ST_DONE : bfs_pkg::ST_POP_WAIT;
         end
         bfs_pkg::ST_POP_WAIT: state_in = bfs_pkg::ST_POP_CHK;
         bfs_pkg::ST_POP_CHK: begin
            state_in = sts.head_visited ? bfs_pkg::ST_POP : bfs_pkg::ST_SCAN_RD;
         end
         bfs_pkg::ST_SCAN_RD: begin
            state_in = sts.scan_more ? bfs_pkg::ST_SCAN_WAIT : bfs_pkg::ST_PW_INIT;
            pw_phase_in = 2'd0;
         end
         bfs_pkg::ST_SCAN_WAIT: state_in = bfs_pkg::ST_SCAN_CHK;
         bfs_pkg::ST_SCAN_CHK:  state_in = bfs_pkg::ST_SCAN_RD;
         bfs_pkg::ST_PW_INIT: begin
            state_in = (pw_phase_ff == 2'd2) ? bfs_pkg::ST_PW_MUL
                     : (sts.pw_more ? bfs_pkg::ST_PW_MUL : bfs_pkg::ST_PW_INIT);
            if (pw_phase_ff != 2'd2 && !sts.pw_more) pw_phase_in = pw_phase_ff + 2'd1;
         end
         bfs_pkg::ST_PW_MUL: state_in = bfs_pkg::ST_PW_RED;
         bfs_pkg::ST_PW_RED: begin
            if (sts.red_done) begin
               if (pw_phase_ff == 2'd2) begin
                  state_in = bfs_pkg::ST_ACC;
               end else if (sts.pw_more) begin
                  state_in = bfs_pkg::ST_PW_MUL;
               end else begin
                  state_in    = bfs_pkg::ST_PW_INIT;
                  pw_phase_in = pw_phase_ff + 2'd1;
               end
            end
         end
         bfs_pkg::ST_ACC:  state_in = bfs_pkg::ST_POP;
         bfs_pkg::ST_DONE: if (rsp_free) state_in = bfs_pkg::ST_CLEAR;
         bfs_pkg::ST_CLEAR: if (sts.clear_done) state_in = bfs_pkg::ST_LOAD;
         default: state_in = bfs_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.pw_sel = bfs_pkg::pw_sel_type'(pw_phase_ff);
      req_tready = 1'b0;
      case (state_ff)
         bfs_pkg::ST_LOAD:      req_tready = 1'b1;
         bfs_pkg::ST_LOAD_WR:   cmd.load_write = 1'b1;
         bfs_pkg::ST_START:     cmd.start_walk = 1'b1;
         bfs_pkg::ST_POP:       cmd.pop = 1'b1;
         bfs_pkg::ST_POP_WAIT:  cmd.head_check = 1'b1;
         bfs_pkg::ST_POP_CHK:   cmd.mark_visit = !sts.head_visited;
         bfs_pkg::ST_SCAN_RD:   cmd.adj_read = 1'b1;
         bfs_pkg::ST_SCAN_CHK:  cmd.scan_check = 1'b1;
         bfs_pkg::ST_PW_INIT:   cmd.pw_init = 1'b1;
         bfs_pkg::ST_PW_MUL:    cmd.pw_mul = 1'b1;
         bfs_pkg::ST_PW_RED:    cmd.pw_red = 1'b1;
         bfs_pkg::ST_ACC:       cmd.acc_add = 1'b1;
         bfs_pkg::ST_DONE: begin
            cmd.result_load = rsp_free;
            cmd.clear_start = rsp_free;
         end
         bfs_pkg::ST_CLEAR:     cmd.clear_step = 1'b1;
         default: ;
      endcase
   end

endmodule

// File: design/bfs_dpath.sv
module bfs_dpath #(
   parameter int MaxVertices = 64,
   parameter int MaxDegree   = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic [6:0]          req_vertex,
   input  logic [6:0]          req_neighbor,
   input  logic [6:0]          root_vertex,
   input  logic [6:0]          vertex_count,
   input  bfs_pkg::cmd_type    cmd,
   output bfs_pkg::status_type sts,
   output logic [29:0]         hash_out,
   output logic                ovf_out
);

   localparam int VW = $clog2(MaxVertices + 1);
   localparam int IW = $clog2(MaxVertices);
   localparam int DW = $clog2(MaxDegree + 1);
   localparam int KW = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
   localparam int SD = MaxVertices * (2 ** KW);
   localparam int AW = IW + KW;
   localparam int QD = SD + 1;
   localparam int QW = $clog2(QD + 1);
   localparam int QA = $clog2(QD);
   localparam int LW = VW;  // depth never exceeds vertex count

   // adjacency memory and walk queue
   logic [6:0]      adj_mem [SD];
   logic [6:0]      adj_rd_ff;
   logic [VW+LW-1:0] q_mem [QD];
   logic [VW+LW-1:0] q_rd_ff;

   // per vertex degree counts and visited marks
   logic [DW-1:0]   deg_mem [MaxVertices];
   logic [DW-1:0]   deg_rd_ff;
   logic            vis_mem [MaxVertices];
   logic            vis_rd_ff;

   logic [IW-1:0]   in_idx_ff;
   logic [6:0]      nb_in_ff;
   logic            in_ok_ff;
   logic            ovf_ff;
   logic [QW-1:0]   head_ff, tail_ff;
   logic [6:0]      n_ff;
   logic [VW-1:0]   u_ff;
   logic [LW-1:0]   d_ff;
   logic [DW-1:0]   k_ff;
   logic [DW-1:0]   kids_ff;
   logic [IW:0]     clr_ff;
   logic [29:0]     acc_ff, res_ff, pw_ff, pd_ff;
   logic [59:0]     prod_ff;
   logic [5:0]      red_ff;
   logic [VW-1:0]   pw_cnt_ff;

   logic            in_ok;
   logic [IW-1:0]   in_idx;
   logic [IW-1:0]   u_idx;
   logic [IW-1:0]   head_idx;
   logic [IW-1:0]   nb_idx;
   logic [IW-1:0]   vis_addr;
   logic [6:0]      nb;
   logic            nb_ok;
   logic            ld_store;
   logic            ld_drop;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [59:0]     shifted;
   logic [VW-1:0]   pw_cnt_cur;

   assign in_ok  = req_vertex >= 7'd1 && {25'd0, req_vertex} <= MaxVertices
                && req_neighbor >= 7'd1 && {25'd0, req_neighbor} <= MaxVertices;
   assign in_idx = IW'(req_vertex - 7'd1);
   assign u_idx  = IW'(u_ff - VW'(1));
   assign head_idx = IW'(q_rd_ff[VW+LW-1:LW] - VW'(1));
   assign wr_addr = {in_idx_ff, deg_rd_ff[KW-1:0]};
   assign rd_addr = {u_idx, k_ff[KW-1:0]};
   assign nb      = adj_rd_ff;
   assign nb_idx  = IW'(nb - 7'd1);
   assign vis_addr = cmd.head_check ? head_idx : nb_idx;
   assign nb_ok   = nb >= 7'd1 && nb <= n_ff && !vis_rd_ff;
   assign ld_store = cmd.load_write && in_ok_ff && deg_rd_ff < DW'(MaxDegree);
   assign ld_drop  = cmd.load_write && in_ok_ff && deg_rd_ff >= DW'(MaxDegree);

   // accepted request held for the store cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_idx_ff <= in_idx;
         nb_in_ff  <= req_neighbor;
         in_ok_ff  <= in_ok;
      end
   end

   // adjacency memory
   always_ff @(posedge clock) begin
      if (ld_store)
         adj_mem[wr_addr] <= nb_in_ff;
      if (cmd.adj_read) adj_rd_ff <= adj_mem[rd_addr];
   end

   // degree and visited memories, one clear address per cycle
   always_ff @(posedge clock) begin
      if (ld_store) deg_mem[in_idx_ff] <= deg_rd_ff + DW'(1);
      else if (cmd.clear_step) deg_mem[IW'(clr_ff)] <= '0;
      if (req_fire) deg_rd_ff <= deg_mem[in_idx];
      else if (cmd.mark_visit) deg_rd_ff <= deg_mem[head_idx];
      if (cmd.mark_visit) vis_mem[head_idx] <= 1'b1;
      else if (cmd.clear_step) vis_mem[IW'(clr_ff)] <= 1'b0;
      vis_rd_ff <= vis_mem[vis_addr];
   end

   // queue memory: push from scan check or walk start, read at head
   always_ff @(posedge clock) begin
      if (cmd.start_walk)
         q_mem[0] <= {VW'(root_vertex), LW'(0)};
      else if (cmd.scan_check && nb_ok && tail_ff < QW'(QD))
         q_mem[QA'(tail_ff)] <= {VW'(nb), LW'(d_ff + LW'(1))};
      if (cmd.pop) q_rd_ff <= q_mem[QA'(head_ff)];
   end

   // walk control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff  <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         clr_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         if (ld_drop) ovf_ff <= 1'b1;
         if (cmd.start_walk) begin
            head_ff <= '0;
            tail_ff <= QW'(1);
            acc_ff  <= '0;
            n_ff    <= ({25'd0, vertex_count} > MaxVertices) ? 7'(MaxVertices) : vertex_count;
         end
         if (cmd.pop) head_ff <= head_ff + QW'(1);
         if (cmd.mark_visit) begin
            u_ff    <= q_rd_ff[VW+LW-1:LW];
            d_ff    <= q_rd_ff[LW-1:0];
            k_ff    <= '0;
            kids_ff <= '0;
         end
         if (cmd.adj_read) k_ff <= k_ff + DW'(1);
         if (cmd.scan_check && nb_ok) begin
            kids_ff <= kids_ff + DW'(1);
            if (tail_ff < QW'(QD)) tail_ff <= tail_ff + QW'(1);
         end
         if (cmd.acc_add)
            acc_ff <= ({1'b0, acc_ff} + {1'b0, pw_ff} >= {1'b0, bfs_pkg::HASH_MOD})
                    ? 30'({1'b0, acc_ff} + {1'b0, pw_ff} - {1'b0, bfs_pkg::HASH_MOD})
                    : acc_ff + pw_ff;
         if (cmd.clear_start) clr_ff <= '0;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + (IW+1)'(1);
            ovf_ff <= 1'b0;
         end
      end
   end

   // power unit: pw = base^e by repeated multiply, then pd*pw for combine
   always_ff @(posedge clock) begin
      if (cmd.pw_init) begin
         case (cmd.pw_sel)
            bfs_pkg::PW_DEPTH: begin pw_ff <= 30'd1; pw_cnt_ff <= VW'(d_ff); end
            bfs_pkg::PW_CHILD: begin pd_ff <= pw_ff; pw_ff <= 30'd1; pw_cnt_ff <= VW'(kids_ff); end
            default: ;
         endcase
      end
      if (cmd.pw_mul) begin
         if (cmd.pw_sel == bfs_pkg::PW_COMBINE) prod_ff <= pw_ff * pd_ff;
         else prod_ff <= pw_ff * ((cmd.pw_sel == bfs_pkg::PW_DEPTH)
                                  ? bfs_pkg::BASE_DEPTH : bfs_pkg::BASE_CHILD);
         red_ff <= 6'd30;
         if (cmd.pw_sel != bfs_pkg::PW_COMBINE) pw_cnt_ff <= pw_cnt_ff - VW'(1);
      end
      if (cmd.pw_red) begin
         if (prod_ff >= shifted) prod_ff <= prod_ff - shifted;
         if (red_ff != 6'd0) red_ff <= red_ff - 6'd1;
         else pw_ff <= (prod_ff >= shifted) ? 30'(prod_ff - shifted) : prod_ff[29:0];
      end
   end

   // restoring reduction: one shifted modulus compare per cycle
   assign shifted = {30'd0, bfs_pkg::HASH_MOD} << red_ff;

   // exponent count as seen after this cycle's load
   always_comb begin
      pw_cnt_cur = pw_cnt_ff;
      if (cmd.pw_init) begin
         case (cmd.pw_sel)
            bfs_pkg::PW_DEPTH: pw_cnt_cur = VW'(d_ff);
            bfs_pkg::PW_CHILD: pw_cnt_cur = VW'(kids_ff);
            default:           pw_cnt_cur = '0;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_ff  <= acc_ff;
         ovf_out <= ovf_ff;
      end
   end

   assign hash_out = res_ff;
   assign sts.root_ok      = root_vertex >= 7'd1 && root_vertex <=
                             (({25'd0, vertex_count} > MaxVertices) ? 7'(MaxVertices)
                                                                    : vertex_count);
   assign sts.queue_empty  = head_ff >= tail_ff;
   assign sts.head_visited = vis_rd_ff;
   assign sts.scan_more    = k_ff < deg_rd_ff;
   assign sts.pw_more      = (cmd.pw_sel != bfs_pkg::PW_COMBINE) && (pw_cnt_cur != '0);
   assign sts.red_done     = (red_ff == 6'd0);
   assign sts.clear_done   = clr_ff == (IW+1)'(MaxVertices - 1);

endmodule

// File: design/bfs_tree_graph_hash.sv
// breadth-first tree hash of a small graph
// req channel: adjacency entries (vertex, neighbor), tlast marks the final
//   entry of a graph; each request is accepted, then stored, before the next.
// rsp channel: one result per graph, the hash mod 1000000007 and a flag
//   telling that some entry was dropped because its vertex list was full.
// csr port: index 0 root vertex, index 1 vertex count; write while idle.
// after the last request the walk starts; each queue entry is popped, each
//   counted vertex has its listed neighbors scanned, and (depth + children + 1)
//   modular multiplies follow, each a multiply, then a 31-step restoring
//   reduction; a final empty pop and the load of the result register follow.
//   one graph is in work at a time.
// after the result is registered, a clearing pass resets degree counts and
//   visited marks; no request is taken then.
// reset: synchronous, active high; registers return to root 1, count 1, and
//   the same clearing pass runs before the first request is taken.
// the rsp register holds its result until taken; a stalled receiver only
//   delays the next graph's result, the block waits in that state.
module bfs_tree_graph_hash #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // vertex[6:0], neighbor[13:7], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // hash_value[29:0], degree_overflow[30], zero fill
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   logic [6:0] root_ff, count_ff;
   logic       rsp_valid_ff;
   logic       req_fire;
   logic       rsp_free;
   logic [29:0] hash_w;
   logic        ovf_w;
   bfs_pkg::cmd_type    cmd;
   bfs_pkg::status_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= 7'd1;
         count_ff <= 7'd1;
      end else if (csr_we) begin
         case (csr_index)
            bfs_pkg::REG_ROOT:  root_ff  <= csr_wdata;
            bfs_pkg::REG_COUNT: count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // result valid
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.result_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   bfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_last(req_tlast),
      .rsp_free(rsp_free), .sts(sts), .cmd(cmd), .req_tready(req_tready)
   );

   bfs_dpath #(.MaxVertices(MAX_VERTICES), .MaxDegree(MAX_DEGREE)) u_dpath (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_vertex(req_tdata[6:0]), .req_neighbor(req_tdata[13:7]),
      .root_vertex(root_ff), .vertex_count(count_ff),
      .cmd(cmd), .sts(sts), .hash_out(hash_w), .ovf_out(ovf_w)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, ovf_w, hash_w};

`ifndef NO_ASSERTIONS
   // result holds while the receiver stalls
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> rsp_free)
      else $error("result loaded over pending one");
   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:0] < bfs_pkg::HASH_MOD)
      else $error("hash out of range");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int NV = 64;
   localparam int ND = 4;
   localparam longint MODV = 1000000007;
   localparam int LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   typedef struct packed {
      logic [29:0] hash_value;
      logic        degree_overflow;
   } graph_result_type;

   bfs_tree_graph_hash u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [6:0] root_reg, count_reg;
   logic [6:0] adj_list [1:NV][0:ND-1];
   int         deg [1:NV];
   logic       ovf;
   graph_result_type hash_expected [$];
   int  errors = 0;
   int  cycle_count = 0;
   bit  no_idle = 0;
   bit  rsp_hold = 0;

   function automatic longint power_mod(longint b, int e);
      longint r;
      r = 1;
      for (int i = 0; i < e; i++) r = (r * b) % MODV;
      return r;
   endfunction

   function automatic logic [29:0] walk_hash();
      int n, head, tail, u, d, kids, v;
      int qv [$];
      int qd [$];
      bit seen [1:NV];
      longint acc;
      n = (count_reg > NV) ? NV : count_reg;
      acc = 0;
      for (int i = 1; i <= NV; i++) seen[i] = 0;
      if (root_reg == 0 || root_reg > n) return '0;
      qv.push_back(root_reg);
      qd.push_back(0);
      while (qv.size() > 0) begin
         u = qv.pop_front();
         d = qd.pop_front();
         if (seen[u]) continue;
         seen[u] = 1;
         kids = 0;
         for (int k = 0; k < deg[u]; k++) begin
            v = adj_list[u][k];
            if (v == 0 || v > n || seen[v]) continue;
            kids++;
            qv.push_back(v);
            qd.push_back(d + 1);
         end
         acc = (acc + (power_mod(13331, d) * power_mod(10007, kids)) % MODV) % MODV;
      end
      return acc[29:0];
   endfunction

   // update the predictor with one accepted request
   task automatic predict_entry(input logic [6:0] v, input logic [6:0] w, input logic l);
      graph_result_type r;
      if (v >= 1 && v <= NV && w >= 1 && w <= NV) begin
         if (deg[v] >= ND) ovf = 1;
         else begin
            adj_list[v][deg[v]] = w;
            deg[v]++;
         end
      end
      if (l) begin
         r.hash_value = walk_hash();
         r.degree_overflow = ovf;
         hash_expected.push_back(r);
         for (int i = 1; i <= NV; i++) deg[i] = 0;
         ovf = 0;
      end
   endtask

   // register write while idle
   task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == bfs_pkg::REG_ROOT) root_reg = val;
      else count_reg = val;
   endtask

   // send one request, with random idle gaps ahead of it
   task automatic send_entry(input logic [6:0] v, input logic [6:0] w, input logic l);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, w, v};
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      predict_entry(v, w, l);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (hash_expected.size() > 0) @(negedge clock);
      // clearing pass plus margin
      repeat (NV + 20) @(negedge clock);
   endtask

   // random graph on vertices 1..n, mostly well formed
   task automatic send_graph(input int n, input bit noisy);
      int entries;
      logic [6:0] v, w;
      entries = $urandom_range(1, 2 * n + 2);
      for (int i = 0; i < entries; i++) begin
         v = $urandom_range(1, n);
         w = $urandom_range(1, n);
         if (noisy && $urandom_range(0, 5) == 0) v = $urandom_range(0, 127);
         if (noisy && $urandom_range(0, 5) == 0) w = $urandom_range(0, 127);
         send_entry(v, w, i == entries - 1);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      graph_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hash_value = rsp_tdata[29:0];
         got.degree_overflow = rsp_tdata[30];
         if (hash_expected.size() == 0) begin
            $error("unexpected result hash_value %0d", got.hash_value);
            errors++;
         end else begin
            want = hash_expected.pop_front();
            if (got.hash_value !== want.hash_value) begin
               $error("hash_value expected %0d actual %0d", want.hash_value, got.hash_value);
               errors++;
            end
            if (got.degree_overflow !== want.degree_overflow) begin
               $error("degree_overflow expected %0d actual %0d",
                      want.degree_overflow, got.degree_overflow);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (rsp_hold) rsp_tready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end else rsp_tready <= 1'b1;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // directed table: vertex, neighbor, last, check value (-1: predictor only)
   typedef struct {
      logic [6:0] v;
      logic [6:0] w;
      logic       l;
      longint     hash_known;
   } entry_row_type;

   entry_row_type dir_rows [] = '{
      '{7'd1, 7'd1, 1'b1, 1},            // after reset, single vertex with self loop
      '{7'd0, 7'd1, 1'b1, -1},           // vertex zero ignored
      '{7'd127, 7'd64, 1'b0, -1},        // out of range vertex
      '{7'd1, 7'd127, 1'b0, -1},         // out of range neighbor
      '{7'd1, 7'd2, 1'b0, -1},
      '{7'd1, 7'd3, 1'b0, -1},
      '{7'd1, 7'd3, 1'b0, -1},           // repeated neighbor
      '{7'd1, 7'd64, 1'b0, -1},
      '{7'd1, 7'd4, 1'b0, -1},           // full list, dropped
      '{7'd2, 7'd1, 1'b0, -1},
      '{7'd64, 7'd64, 1'b0, -1},         // self loop at top vertex
      '{7'd3, 7'd2, 1'b1, -1}
   };

   initial begin
      longint hk;
      graph_result_type want;
      root_reg = 1;
      count_reg = 1;
      ovf = 0;
      for (int i = 1; i <= NV; i++) deg[i] = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      repeat (NV + 4) @(negedge clock);

      // directed part, first row at reset settings
      foreach (dir_rows[i]) begin
         if (i == 2) begin
            wait_drained();
            write_reg(bfs_pkg::REG_COUNT, 7'd64);
            write_reg(bfs_pkg::REG_ROOT, 7'd1);
         end
         hk = dir_rows[i].hash_known;
         send_entry(dir_rows[i].v, dir_rows[i].w, dir_rows[i].l);
         if (hk >= 0) begin
            want = hash_expected[$];
            if (want.hash_value != hk) begin
               $error("hash_value expected %0d actual %0d", hk, want.hash_value);
               errors++;
            end
         end
      end
      wait_drained();
      // extremes: root zero, root above count, count zero, count too large
      write_reg(bfs_pkg::REG_ROOT, 7'd0);
      send_entry(7'd1, 7'd2, 1'b1);
      wait_drained();
      write_reg(bfs_pkg::REG_ROOT, 7'd10);
      write_reg(bfs_pkg::REG_COUNT, 7'd5);
      send_entry(7'd10, 7'd1, 1'b1);
      wait_drained();
      write_reg(bfs_pkg::REG_COUNT, 7'd0);
      write_reg(bfs_pkg::REG_ROOT, 7'd1);
      send_entry(7'd1, 7'd1, 1'b1);
      wait_drained();
      write_reg(bfs_pkg::REG_COUNT, 7'd127);
      write_reg(bfs_pkg::REG_ROOT, 7'd64);
      send_entry(7'd64, 7'd63, 1'b0);
      send_entry(7'd63, 7'd64, 1'b1);
      wait_drained();

      // random phases through several settings
      for (int ph = 0; ph < 10; ph++) begin
         int n;
         n = (ph % 3 == 0) ? 64 : $urandom_range(1, 16);
         write_reg(bfs_pkg::REG_COUNT, ph == 4 ? 7'd127 : 7'(n));
         write_reg(bfs_pkg::REG_ROOT,
                   ph == 6 ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, n)));
         if (ph == 3) begin
            // long receiver hold while requests keep coming
            rsp_hold = 1;
            fork
               begin
                  repeat (60000) @(negedge clock);
                  rsp_hold = 0;
               end
            join_none
         end
         if (ph == 9) no_idle = 1;
         for (int g = 0; g < 5; g++) begin
            send_graph(n, $urandom_range(0, 3) == 0);
         end
         wait_drained();
      end

      req_tvalid <= 1'b0;
      while (hash_expected.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: bfs_tree_graph_hash.f
design/bfs_pkg.sv
design/bfs_ctrl.sv
design/bfs_dpath.sv
design/bfs_tree_graph_hash.sv
dv/tb.sv
